// ===== rtl/rled_pkg.sv =====
// shared types and constants for the rgb led bit encoder
// no dependencies; imported by the front, queue, back and top level
package rled_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned BRIGHT_W      = 7;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned SUM_W         = 15;  // c*p+50 stays below 25600
  localparam int unsigned RECIP_W       = 13;
  localparam int unsigned PROD_W        = SUM_W + RECIP_W;
  localparam int unsigned BITS_PER_LED  = 3 * CHAN_W;
  localparam int unsigned CNT_W         = $clog2(BITS_PER_LED);
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = QUEUE_PTR_W + 1;

  localparam logic [BRIGHT_W-1:0] PERCENT_FULL = 7'd100;
  localparam logic [SUM_W-1:0]    ROUND_HALF   = 15'd50;
  // x/100 == (x*5243)>>19 for every x below 43690
  localparam logic [RECIP_W-1:0]  RECIP_100    = 13'd5243;
  localparam int unsigned         RECIP_SHIFT  = 19;

  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(BITS_PER_LED - 1);

  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_CODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_CODE  = 2'd2;

  localparam logic [BRIGHT_W-1:0]   RST_BRIGHTNESS = 7'd100;
  localparam logic [CFG_DATA_W-1:0] RST_ONE_CODE   = 16'd58;
  localparam logic [CFG_DATA_W-1:0] RST_ZERO_CODE  = 16'd29;

  typedef struct packed {
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] blue;
    logic              last_led;
  } led_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] one_code;
    logic [CFG_DATA_W-1:0] zero_code;
  } codes_t;

endpackage

// ===== rtl/rled_front.sv =====
// front end: accepts an led item and scales each channel by the brightness
// a registered product plus rounding, then a combinational reciprocal divide; uses rled_pkg
module rled_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rled_pkg::CHAN_W-1:0]   red,
  input  logic [rled_pkg::CHAN_W-1:0]   green,
  input  logic [rled_pkg::CHAN_W-1:0]   blue,
  input  logic                          last_led,
  input  logic [rled_pkg::BRIGHT_W-1:0] brightness,
  output logic                          push,
  output rled_pkg::led_t                push_item,
  input  logic                          queue_full
);
  import rled_pkg::*;

  logic [BRIGHT_W-1:0] pct;
  logic                s1_valid;
  logic [SUM_W-1:0]    s1_green;
  logic [SUM_W-1:0]    s1_red;
  logic [SUM_W-1:0]    s1_blue;
  logic                s1_last;
  logic [PROD_W-1:0]   q_green;
  logic [PROD_W-1:0]   q_red;
  logic [PROD_W-1:0]   q_blue;

  assign pct = (brightness > PERCENT_FULL) ? PERCENT_FULL : brightness;

  assign push     = s1_valid && !queue_full;
  assign in_ready = !s1_valid || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_green <= SUM_W'(green * pct) + ROUND_HALF;
      s1_red   <= SUM_W'(red * pct) + ROUND_HALF;
      s1_blue  <= SUM_W'(blue * pct) + ROUND_HALF;
      s1_last  <= last_led;
    end
  end

  // divide by a hundred through the reciprocal
  assign q_green = PROD_W'(s1_green) * PROD_W'(RECIP_100);
  assign q_red   = PROD_W'(s1_red) * PROD_W'(RECIP_100);
  assign q_blue  = PROD_W'(s1_blue) * PROD_W'(RECIP_100);

  always_comb begin
    push_item.green    = q_green[RECIP_SHIFT +: CHAN_W];
    push_item.red      = q_red[RECIP_SHIFT +: CHAN_W];
    push_item.blue     = q_blue[RECIP_SHIFT +: CHAN_W];
    push_item.last_led = s1_last;
  end

endmodule

// ===== rtl/rled_queue.sv =====
// short queue of scaled led items between the front and back ends
// uses rled_pkg for the item type and depth
module rled_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rled_pkg::led_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rled_pkg::led_t head
);
  import rled_pkg::*;

  led_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/rled_back.sv =====
// back end: serialises the queue head into 24 codes, green red blue, msb first
// registered output stage; uses rled_pkg
module rled_back #(
  parameter int unsigned CODE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  rled_pkg::led_t        head,
  output logic                  pop,
  input  rled_pkg::codes_t      codes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_WIDTH-1:0] pulse_code,
  output logic                  led_done,
  output logic                  frame_end
);
  import rled_pkg::*;

  logic [CNT_W-1:0]        slot;
  logic [BITS_PER_LED-1:0] grb;
  logic [CNT_W-1:0]        bit_idx;
  logic                    load;
  logic                    cur_bit;

  assign grb     = {head.green, head.red, head.blue};
  assign bit_idx = LAST_SLOT - slot;
  assign cur_bit = grb[bit_idx];
  assign load    = (!out_valid || out_ready) && !empty;
  assign pop     = load && (slot == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pulse_code <= cur_bit ? codes.one_code[CODE_WIDTH-1:0]
                            : codes.zero_code[CODE_WIDTH-1:0];
      led_done   <= (slot == LAST_SLOT);
      frame_end  <= (slot == LAST_SLOT) && head.last_led;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk) disable iff (rst) slot <= LAST_SLOT)
    else $error("slot counter out of range");
  a_frame_on_done: assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_end |-> led_done)
    else $error("frame end without led done");
  a_wrap_after_pop: assert property (@(posedge clk) disable iff (rst)
      pop |=> slot == '0)
    else $error("slot counter did not wrap after the last code");
`endif

endmodule

// ===== rtl/rgb_led_bit_encoder.sv =====
// top level of the rgb led bit encoder: configuration registers plus front,
// queue and back ends; depends on rled_pkg, rled_front, rled_queue, rled_back
//
//  channel  handshake             payload
//  -------  --------------------  ----------------------------------
//  in       in_valid / in_ready   red, green, blue, last_led
//  out      out_valid / out_ready pulse_code, led_done, frame_end
//  cfg      cfg_we                cfg_index, cfg_data
//
// each led item gives 24 codes, one per cycle while out_ready is high
// and the queue is not empty; a low out_ready holds the current code
// an accepted item passes the front register and the queue memory
// synchronous reset loads brightness 100, one code 58, zero code 29
// the queue lets the front take items while the output stalls
module rgb_led_bit_encoder #(
  parameter int unsigned CODE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rled_pkg::CHAN_W-1:0]      red,
  input  logic [rled_pkg::CHAN_W-1:0]      green,
  input  logic [rled_pkg::CHAN_W-1:0]      blue,
  input  logic                             last_led,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [CODE_WIDTH-1:0]            pulse_code,
  output logic                             led_done,
  output logic                             frame_end,
  input  logic                             cfg_we,
  input  logic [rled_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rled_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rled_pkg::*;

  logic [BRIGHT_W-1:0] brightness;
  codes_t              codes;
  logic                push;
  led_t                push_item;
  logic                queue_full;
  logic                queue_empty;
  logic                pop;
  led_t                head;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= RST_BRIGHTNESS;
      codes.one_code  <= RST_ONE_CODE;
      codes.zero_code <= RST_ZERO_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness      <= cfg_data[BRIGHT_W-1:0];
        REG_ONE_CODE:   codes.one_code  <= cfg_data;
        REG_ZERO_CODE:  codes.zero_code <= cfg_data;
        default: ;
      endcase
    end
  end

  rled_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_led   (last_led),
    .brightness (brightness),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  rled_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  rled_back #(
    .CODE_WIDTH (CODE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .head       (head),
    .pop        (pop),
    .codes      (codes),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_code (pulse_code),
    .led_done   (led_done),
    .frame_end  (frame_end)
  );

endmodule

// ===== verif/tb_rgb_led_bit_encoder.sv =====
// self-checking testbench for rgb_led_bit_encoder: a directed table, then random
// leds under several register settings; depends on rled_pkg and the block rtl
module tb_rgb_led_bit_encoder;
  import rled_pkg::*;

  localparam int unsigned CODE_W        = 16;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_LEDS    = 52;
  localparam int unsigned PLAN_ROWS     = 29;
  localparam int unsigned MAX_PRINTS    = 100;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;  // no register behind it

  typedef enum logic {ROW_LED, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_BLOCK} rx_mode_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [CHAN_W-1:0]      r;
    logic [CHAN_W-1:0]      g;
    logic [CHAN_W-1:0]      b;
    logic                   last;
    logic                   typed;  // grb below is the scaled colour to expect
    logic [3*CHAN_W-1:0]    grb;
  } plan_row_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              done;
    logic              fend;
  } code_slot_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAN_W-1:0]      red = '0;
  logic [CHAN_W-1:0]      green = '0;
  logic [CHAN_W-1:0]      blue = '0;
  logic                   last_led = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CODE_W-1:0]      pulse_code;
  logic                   led_done;
  logic                   frame_end;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register copies for prediction
  logic [BRIGHT_W-1:0]   bright_pct = RST_BRIGHTNESS;
  logic [CFG_DATA_W-1:0] one_val    = RST_ONE_CODE;
  logic [CFG_DATA_W-1:0] zero_val   = RST_ZERO_CODE;

  code_slot_t  pending_codes[$];
  int unsigned mismatches = 0;
  int unsigned codes_seen = 0;
  int unsigned burst_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [7:0]  rx_tick = '0;

  //  kind     idx             data      r      g      b    last  typed grb
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 24'hffffff},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h80, 8'h01, 8'haa, 1'b0, 1'b1, 24'h0180aa},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h55, 8'h7f, 8'hfe, 1'b1, 1'b1, 24'h7f55fe},
    '{ROW_CFG, REG_ONE_CODE,   16'hffff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG, REG_ZERO_CODE,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'h00, 8'hff, 1'b1, 1'b1, 24'h00ffff},
    '{ROW_LED, REG_NONE,       16'h0000, 8'ha5, 8'h5a, 8'hc3, 1'b0, 1'b1, 24'h5aa5c3},
    '{ROW_CFG, REG_BRIGHTNESS, 16'd0,    8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 24'h000000},
    '{ROW_CFG, REG_BRIGHTNESS, 16'd50,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'h01, 8'h03, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h64, 8'hc8, 8'hc9, 1'b1, 1'b0, 24'h000000},
    '{ROW_CFG, REG_BRIGHTNESS, 16'd1,    8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'h31, 8'h32, 1'b0, 1'b0, 24'h000000},
    // brightness above full scale acts as full scale
    '{ROW_CFG, REG_BRIGHTNESS, 16'd101,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'h80, 8'h7f, 1'b1, 1'b1, 24'h80ff7f},
    '{ROW_CFG, REG_BRIGHTNESS, 16'd127,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 24'h341256},
    // upper data bits are dropped by the brightness register
    '{ROW_CFG, REG_BRIGHTNESS, 16'hff32, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 24'h000000},
    // write to the unused index must change nothing
    '{ROW_CFG, REG_NONE,       16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 24'h000000},
    '{ROW_CFG, REG_ONE_CODE,   16'h8001, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG, REG_ZERO_CODE,  16'h7ffe, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG, REG_BRIGHTNESS, 16'd100,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_LED, REG_NONE,       16'h0000, 8'h0f, 8'hf0, 8'h3c, 1'b1, 1'b1, 24'hf00f3c},
    '{ROW_CFG, REG_ONE_CODE,   16'd58,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG, REG_ZERO_CODE,  16'd29,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000}
  };

  rgb_led_bit_encoder #(.CODE_WIDTH(CODE_W)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_led   (last_led),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_code (pulse_code),
    .led_done   (led_done),
    .frame_end  (frame_end),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] c,
                                                    input logic [BRIGHT_W-1:0] p);
    int unsigned q;
    q = (p > PERCENT_FULL) ? PERCENT_FULL : p;
    return CHAN_W'((c * q + 50) / 100);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // grb is the scaled colour, green byte on top; codes go out msb first
  task automatic push_led_codes(input logic [3*CHAN_W-1:0] grb, input logic last);
    code_slot_t slot;
    for (int i = BITS_PER_LED - 1; i >= 0; i--) begin
      slot.code = grb[i] ? one_val[CODE_W-1:0] : zero_val[CODE_W-1:0];
      slot.done = (i == 0);
      slot.fend = (i == 0) && last;
      pending_codes.push_back(slot);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at code %0d: %s got %h want %h", codes_seen, what, got, want);
    mismatches++;
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  task automatic send_led(input logic [CHAN_W-1:0] r, g, b, input logic last,
                          input logic typed, input logic [3*CHAN_W-1:0] grb);
    logic [3*CHAN_W-1:0] pattern;
    red      <= r;
    green    <= g;
    blue     <= b;
    last_led <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pattern = typed ? grb : {dim_channel(g, bright_pct), dim_channel(r, bright_pct),
                             dim_channel(b, bright_pct)};
    push_led_codes(pattern, last);
    pace_sender();
  endtask

  // stop sending and let every outstanding code drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: bright_pct = data[BRIGHT_W-1:0];
      REG_ONE_CODE:   one_val = data;
      REG_ZERO_CODE:  zero_val = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver stall pattern; the mode is redrawn at random when its countdown runs out
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_QUARTER: out_ready <= (rx_tick[1:0] == 2'd0);
      RX_BLOCK:   out_ready <= rx_tick[4];
      default:    out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    code_slot_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected code", pulse_code, 0);
      end else begin
        want = pending_codes.pop_front();
        if (pulse_code !== want.code) report_mismatch("pulse_code", pulse_code, want.code);
        if (led_done !== want.done) report_mismatch("led_done", led_done, want.done);
        if (frame_end !== want.fend) report_mismatch("frame_end", frame_end, want.fend);
      end
      codes_seen++;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] bright_data;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_led(plan[i].r, plan[i].g, plan[i].b, plan[i].last, plan[i].typed,
                 plan[i].grb);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: bright_data = CFG_DATA_W'(PERCENT_FULL);
        1: bright_data = '0;
        2: bright_data = 16'hff7f;
        default: bright_data = CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      write_reg(REG_BRIGHTNESS, bright_data);
      case (ph)
        1: begin
          write_reg(REG_ONE_CODE, '1);
          write_reg(REG_ZERO_CODE, '0);
        end
        2: begin
          write_reg(REG_ONE_CODE, '0);
          write_reg(REG_ZERO_CODE, '1);
        end
        default: begin
          write_reg(REG_ONE_CODE, CFG_DATA_W'($urandom_range(0, 65535)));
          write_reg(REG_ZERO_CODE, CFG_DATA_W'($urandom_range(0, 65535)));
        end
      endcase
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 65535)));
      for (int n = 0; n < PHASE_LEDS; n++) begin
        // hold off now and then until the block has emptied
        if ((ph == 3 && n == PHASE_LEDS / 2) || $urandom_range(0, 49) == 0)
          settle();
        send_led(pick_channel(), pick_channel(), pick_channel(),
                 ($urandom_range(0, 3) == 0), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("FAILURE");
    $finish;
  end

endmodule
